// ===== sv/rss_pkg.sv =====
package rss_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 12;
    localparam int POS_W  = 10;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_EVAL  = 6'b000100,
        S_EVALH = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } rd_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } rd_rsp_t;

    typedef struct packed {
        state_t state;
        logic   rd_re;
    } ctrl_stat_t;

endpackage

// ===== sv/rss_store.sv =====
module rss_store
    import rss_pkg::*;
(
    input  logic    clk,
    input  wr_req_t wr_req,
    input  rd_req_t rd_req,
    output rd_rsp_t rd_rsp
);

    logic signed [DATA_W-1:0] mem_reg [DEPTH];
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.we)
        begin
            mem_reg[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.re)
        begin
            rd_a_reg <= mem_reg[rd_req.addr_a];
            rd_b_reg <= mem_reg[rd_req.addr_b];
        end
    end

    assign rd_rsp.a = rd_a_reg;
    assign rd_rsp.b = rd_b_reg;

endmodule

// ===== sv/rss_ctrl.sv =====
module rss_ctrl
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  element_count,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [POS_W-1:0]  s_slot,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [POS_W-1:0]  m_position,
    output wr_req_t           wr_req,
    output rd_req_t           rd_req,
    input  rd_rsp_t           rd_rsp,
    output ctrl_stat_t        stat
);

    state_t                   state_reg, state_next;
    logic signed [IDX_W-1:0]  low_reg, low_next;
    logic signed [IDX_W-1:0]  high_reg, high_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] vm_reg, vm_next;
    logic                     res_found_reg, res_found_next;
    logic [POS_W-1:0]         res_pos_reg, res_pos_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    logic [POS_W-1:0]         out_pos_reg, out_pos_next;

    logic [CNT_W-1:0]         n_eff;
    logic [IDX_W:0]           mid_sum;
    logic [ADDR_W-1:0]        mid_calc;
    logic signed [IDX_W-1:0]  mid_ext;
    logic                     in_acc;
    logic                     out_free;

    assign n_eff    = (element_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : element_count;
    assign mid_sum  = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_calc = mid_sum[ADDR_W:1];
    assign mid_ext  = signed'(IDX_W'(mid_reg));
    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        vm_next        = vm_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        wr_req.we      = 1'b0;
        wr_req.addr    = s_slot[ADDR_W-1:0];
        wr_req.data    = s_value;
        rd_req.re      = 1'b0;
        rd_req.addr_a  = mid_calc;
        rd_req.addr_b  = low_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_action == ACT_SEARCH)
                    begin
                        key_next   = signed'(s_value);
                        low_next   = '0;
                        high_next  = signed'({1'b0, n_eff}) - IDX_W'(1);
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        wr_req.we = ({1'b0, s_slot} < (POS_W + 1)'(DEPTH));
                    end
                end
            end
            S_CHECK:
            begin
                if (low_reg <= high_reg)
                begin
                    rd_req.re  = 1'b1;
                    mid_next   = mid_calc;
                    state_next = S_EVAL;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = S_DONE;
                end
            end
            S_EVAL:
            begin
                if (rd_rsp.a == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = POS_W'(mid_reg);
                    state_next     = S_DONE;
                end
                else if (rd_rsp.b <= rd_rsp.a)
                begin
                    if (rd_rsp.b <= key_reg && key_reg <= rd_rsp.a)
                    begin
                        high_next = mid_ext - IDX_W'(1);
                    end
                    else
                    begin
                        low_next = mid_ext + IDX_W'(1);
                    end
                    state_next = S_CHECK;
                end
                else
                begin
                    rd_req.re     = 1'b1;
                    rd_req.addr_a = high_reg[ADDR_W-1:0];
                    vm_next       = rd_rsp.a;
                    state_next    = S_EVALH;
                end
            end
            S_EVALH:
            begin
                if (vm_reg <= key_reg && key_reg <= rd_rsp.a)
                begin
                    low_next = mid_ext + IDX_W'(1);
                end
                else
                begin
                    high_next = mid_ext - IDX_W'(1);
                end
                state_next = S_CHECK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_pos_next   = res_pos_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg       <= low_next;
        high_reg      <= high_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        vm_reg        <= vm_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_found    = out_found_reg;
    assign m_position = out_pos_reg;
    assign stat.state = state_reg;
    assign stat.rd_re = rd_req.re;

endmodule

// ===== sv/rotated_sorted_search.sv =====
// A load item writes one slot of the element store.
// A search item repeats halving steps of CHECK and EVAL, plus EVALH when the low half is
// not sorted, then passes DONE; the dual-read store port fetches mid and low together.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears the FSM state, the output valid flag and element_count; the store is undefined until loaded.
module rotated_sorted_search
    import rss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // slot_index [9:0], data_value [41:10], zero fill
    input  logic        s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // position [9:0], zero fill
    output logic        m_tuser   // found
);

    logic [CNT_W-1:0] count_reg;
    logic             cfg_wr;
    wr_req_t          wr_req;
    rd_req_t          rd_req;
    rd_rsp_t          rd_rsp;
    ctrl_stat_t       stat;
    logic [POS_W-1:0] position;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ELEMENT_COUNT);
    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {(32 - CNT_W)'(0), count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            count_reg <= pwdata[CNT_W-1:0];
        end
    end

    rss_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (count_reg),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_action      (s_tuser),
        .s_slot        (s_tdata[9:0]),
        .s_value       (s_tdata[41:10]),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_found       (m_tuser),
        .m_position    (position),
        .wr_req        (wr_req),
        .rd_req        (rd_req),
        .rd_rsp        (rd_rsp),
        .stat          (stat)
    );

    rss_store u_store (
        .clk    (clk),
        .wr_req (wr_req),
        .rd_req (rd_req),
        .rd_rsp (rd_rsp)
    );

    assign m_tdata = {(16 - POS_W)'(0), position};

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("A load item produced a result.");

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_SEARCH) |=> stat.state == S_CHECK)
        else $error("An accepted search did not start.");

    a_read_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        stat.rd_re |-> (stat.state == S_CHECK || stat.state == S_EVAL))
        else $error("A store read was issued outside a search step.");

    a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.state == S_EVAL || stat.state == S_EVALH) |-> $past(stat.rd_re))
        else $error("A compare ran without a store read before it.");

    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.we |-> stat.state == S_IDLE)
        else $error("The store was written during a search.");

endmodule
